/* sv/trm_pkg.sv */
// Shared definitions for the tiny register machine execute block.
// Holds command and operand-kind codes and the decoded request format
// passed from the front decoder through the queue to the back end.
package trm_pkg;

  localparam logic [2:0] CMD_HLT = 3'd0;
  localparam logic [2:0] CMD_PRN = 3'd1;
  localparam logic [2:0] CMD_JMP = 3'd2;
  localparam logic [2:0] CMD_JPN = 3'd3;
  localparam logic [2:0] CMD_ADD = 3'd4;
  localparam logic [2:0] CMD_SUB = 3'd5;
  localparam logic [2:0] CMD_MOV = 3'd6;

  localparam logic [1:0] KIND_REG = 2'd0;
  localparam logic [1:0] KIND_MEM = 2'd1;

  // Restoring steps that reduce a 10-bit jump target modulo a program
  // size of at least 16 words.
  localparam int MOD_STEPS = 6;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    SRC_REGA,
    SRC_REGB,
    SRC_MEM,
    SRC_IMM
  } src_t;

  typedef enum logic [1:0] {
    ALU_PASS,
    ALU_ADD,
    ALU_SUB
  } alu_t;

  typedef struct packed {
    logic        halt;
    logic        print;
    logic        br_always;
    logic        br_zero;
    logic        br_nonpos;
    alu_t        alu;
    src_t        src;
    logic        reg_we;
    logic [2:0]  reg_waddr;
    logic        mem_we;
    logic [5:0]  mem_waddr;
    logic        ra_ok;
    logic [2:0]  ra_addr;
    logic        rb_ok;
    logic [2:0]  rb_addr;
    logic        mem_ok;
    logic [5:0]  mem_raddr;
    logic [30:0] imm;
    logic [9:0]  target;
  } op_t;

endpackage

/* sv/trm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Read during write at the same address returns the old contents.
// No dependencies.
module trm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/trm_front.sv */
// Front decoder: classifies one instruction into a decoded request.
// Resolves operand routing, range checks and the jump target modulo.
// Depends on trm_pkg.
module trm_front
  import trm_pkg::*;
#(
  parameter int NUM_REGS   = 5,
  parameter int MEM_WORDS  = 64,
  parameter int PROG_WORDS = 1024
) (
  input  logic [2:0]  command,
  input  logic [1:0]  first_kind,
  input  logic [2:0]  first_reg,
  input  logic [5:0]  first_addr,
  input  logic [30:0] first_value,
  input  logic [1:0]  second_kind,
  input  logic [2:0]  second_reg,
  input  logic [5:0]  second_addr,
  input  logic [30:0] second_value,
  input  logic [9:0]  jump_target,
  output op_t         op
);

  logic       r1_ok;
  logic       r2_ok;
  logic       a1_ok;
  logic       a2_ok;
  logic [9:0] tgt;

  assign r1_ok = 32'(first_reg) < 32'(NUM_REGS);
  assign r2_ok = 32'(second_reg) < 32'(NUM_REGS);
  assign a1_ok = 32'(first_addr) < 32'(MEM_WORDS);
  assign a2_ok = 32'(second_addr) < 32'(MEM_WORDS);

  // Restoring reduction: subtract program size shifted down one bit per step.
  always_comb begin
    tgt = jump_target;
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (32'(tgt) >= 32'(PROG_WORDS << k)) begin
        tgt = tgt - 10'(PROG_WORDS << k);
      end
    end
  end

  always_comb begin
    op           = '0;
    op.alu       = ALU_PASS;
    op.src       = SRC_IMM;
    op.ra_addr   = first_reg;
    op.ra_ok     = r1_ok;
    op.rb_addr   = second_reg;
    op.rb_ok     = r2_ok;
    op.imm       = second_value;
    op.target    = tgt;
    case (command)
      CMD_HLT: begin
        op.halt = 1'b1;
      end
      CMD_PRN: begin
        op.print = 1'b1;
        op.imm   = first_value;
        if (first_kind == KIND_REG) begin
          op.src = SRC_REGA;
        end else if (first_kind == KIND_MEM) begin
          op.src       = SRC_MEM;
          op.mem_raddr = first_addr;
          op.mem_ok    = a1_ok;
        end
      end
      CMD_JMP: begin
        if (first_kind == KIND_REG) begin
          op.br_zero = 1'b1;
        end else begin
          op.br_always = 1'b1;
        end
      end
      CMD_JPN: begin
        op.br_nonpos = 1'b1;
      end
      CMD_ADD, CMD_SUB: begin
        op.alu       = (command == CMD_ADD) ? ALU_ADD : ALU_SUB;
        op.reg_we    = r1_ok;
        op.reg_waddr = first_reg;
        if (second_kind == KIND_REG) begin
          op.src = SRC_REGB;
        end else if (second_kind == KIND_MEM) begin
          op.src       = SRC_MEM;
          op.mem_raddr = second_addr;
          op.mem_ok    = a2_ok;
        end
      end
      CMD_MOV: begin
        if (first_kind == KIND_REG) begin
          if (second_kind == KIND_REG) begin
            op.src       = SRC_REGA;
            op.reg_we    = r2_ok;
            op.reg_waddr = second_reg;
          end else if (second_kind == KIND_MEM) begin
            op.src       = SRC_REGA;
            op.mem_we    = a2_ok;
            op.mem_waddr = second_addr;
          end else begin
            op.reg_we    = r1_ok;
            op.reg_waddr = first_reg;
          end
        end else if (first_kind == KIND_MEM) begin
          if (second_kind == KIND_REG) begin
            op.src       = SRC_MEM;
            op.mem_raddr = first_addr;
            op.mem_ok    = a1_ok;
            op.reg_we    = r2_ok;
            op.reg_waddr = second_reg;
          end else if (second_kind != KIND_MEM) begin
            op.mem_we    = a1_ok;
            op.mem_waddr = first_addr;
          end
        end
      end
      default: begin
        op.halt = 1'b0;
      end
    endcase
  end

endmodule

/* sv/trm_queue.sv */
// Short FIFO of decoded requests between the front decoder and back end.
// Depends on trm_pkg.
module trm_queue
  import trm_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op,
  output logic full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  op_t           slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [PW-1:0] wr_ptr_next;
  logic [PW-1:0] rd_ptr_next;

  assign wr_ptr_next = (32'(wr_ptr) == 32'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (32'(rd_ptr) == 32'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  assign head_valid = (count != '0);
  assign full       = (32'(count) == 32'(DEPTH));
  assign head_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/trm_back.sv */
// Back end: register file, data memory, program counter and halt flag.
// Issues RAM reads on pop, executes in one stage with write forwarding,
// and holds the result in an output register. Depends on trm_pkg, trm_ram.
module trm_back
  import trm_pkg::*;
#(
  parameter int NUM_REGS   = 5,
  parameter int MEM_WORDS  = 64,
  parameter int PROG_WORDS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  op_t                head_op,
  output logic               pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         next_pc,
  output logic               print_valid,
  output logic signed [31:0] print_value,
  output logic               halted
);

  localparam int REG_AW    = $clog2(NUM_REGS);
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int PC_W      = $clog2(PROG_WORDS);
  localparam int CLR_DEPTH = (MEM_WORDS > NUM_REGS) ? MEM_WORDS : NUM_REGS;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  logic [CLR_W-1:0]  clr_idx;
  logic [31:0]       clr_ext;
  logic              e_valid;
  op_t               e_op;
  logic              e_commit;
  logic [PC_W-1:0]   pc;
  logic              halt_flag;

  logic              rf_fwd_valid;
  logic [REG_AW-1:0] rf_fwd_addr;
  logic [31:0]       rf_fwd_data;
  logic              mem_fwd_valid;
  logic [MEM_AW-1:0] mem_fwd_addr;
  logic [31:0]       mem_fwd_data;

  logic [31:0]       h_ra_ext;
  logic [31:0]       h_rb_ext;
  logic [31:0]       h_m_ext;
  logic [31:0]       e_ra_ext;
  logic [31:0]       e_rb_ext;
  logic [31:0]       e_mr_ext;
  logic [31:0]       e_rw_ext;
  logic [31:0]       e_mw_ext;
  logic [REG_AW-1:0] e_ra;
  logic [REG_AW-1:0] e_rb;
  logic [MEM_AW-1:0] e_mr;
  logic [REG_AW-1:0] e_rw;
  logic [MEM_AW-1:0] e_mw;

  logic [31:0]       rfa_q;
  logic [31:0]       rfb_q;
  logic [31:0]       mem_q;
  logic [31:0]       va;
  logic [31:0]       vb;
  logic [31:0]       vm;
  logic [31:0]       src_val;
  logic [31:0]       res;
  logic              live;
  logic              branch;
  logic [PC_W-1:0]   pc_inc;
  logic [PC_W-1:0]   pc_next;
  logic [31:0]       pc_ext;
  logic [31:0]       tgt_ext;
  logic              c_reg_we;
  logic              c_mem_we;

  logic              rf_we;
  logic [REG_AW-1:0] rf_waddr;
  logic [31:0]       rf_wdata;
  logic              dm_we;
  logic [MEM_AW-1:0] dm_waddr;
  logic [31:0]       dm_wdata;

  assign e_commit = e_valid && (!out_valid || !out_stall);
  assign pop      = head_valid && (!e_valid || e_commit);

  assign h_ra_ext = 32'(head_op.ra_addr);
  assign h_rb_ext = 32'(head_op.rb_addr);
  assign h_m_ext  = 32'(head_op.mem_raddr);
  assign e_ra_ext = 32'(e_op.ra_addr);
  assign e_rb_ext = 32'(e_op.rb_addr);
  assign e_mr_ext = 32'(e_op.mem_raddr);
  assign e_rw_ext = 32'(e_op.reg_waddr);
  assign e_mw_ext = 32'(e_op.mem_waddr);
  assign e_ra     = e_ra_ext[REG_AW-1:0];
  assign e_rb     = e_rb_ext[REG_AW-1:0];
  assign e_mr     = e_mr_ext[MEM_AW-1:0];
  assign e_rw     = e_rw_ext[REG_AW-1:0];
  assign e_mw     = e_mw_ext[MEM_AW-1:0];
  assign clr_ext  = 32'(clr_idx);

  // Clearing pass writes zero; otherwise the committing request writes.
  always_comb begin
    if (clearing) begin
      rf_we    = clr_ext < 32'(NUM_REGS);
      rf_waddr = clr_ext[REG_AW-1:0];
      rf_wdata = '0;
      dm_we    = clr_ext < 32'(MEM_WORDS);
      dm_waddr = clr_ext[MEM_AW-1:0];
      dm_wdata = '0;
    end else begin
      rf_we    = c_reg_we;
      rf_waddr = e_rw;
      rf_wdata = res;
      dm_we    = c_mem_we;
      dm_waddr = e_mw;
      dm_wdata = res;
    end
  end

  trm_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (pop),
    .raddr (h_ra_ext[REG_AW-1:0]),
    .rdata (rfa_q)
  );

  trm_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (pop),
    .raddr (h_rb_ext[REG_AW-1:0]),
    .rdata (rfb_q)
  );

  trm_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (pop),
    .raddr (h_m_ext[MEM_AW-1:0]),
    .rdata (mem_q)
  );

  always_comb begin
    // Forward the last write; the RAM read issued alongside it saw old data.
    va = (rf_fwd_valid && rf_fwd_addr == e_ra) ? rf_fwd_data : rfa_q;
    vb = (rf_fwd_valid && rf_fwd_addr == e_rb) ? rf_fwd_data : rfb_q;
    vm = (mem_fwd_valid && mem_fwd_addr == e_mr) ? mem_fwd_data : mem_q;
    if (!e_op.ra_ok) begin
      va = '0;
    end
    if (!e_op.rb_ok) begin
      vb = '0;
    end
    if (!e_op.mem_ok) begin
      vm = '0;
    end

    case (e_op.src)
      SRC_REGA: src_val = va;
      SRC_REGB: src_val = vb;
      SRC_MEM:  src_val = vm;
      default:  src_val = {1'b0, e_op.imm};
    endcase

    case (e_op.alu)
      ALU_ADD: res = va + src_val;
      ALU_SUB: res = va - src_val;
      default: res = src_val;
    endcase

    live     = !halt_flag;
    c_reg_we = e_commit && live && e_op.reg_we;
    c_mem_we = e_commit && live && e_op.mem_we;
    branch   = live && (e_op.br_always ||
                        (e_op.br_zero && va == '0) ||
                        (e_op.br_nonpos && (va == '0 || va[31])));

    pc_inc  = (32'(pc) == 32'(PROG_WORDS - 1)) ? '0 : pc + 1'b1;
    tgt_ext = 32'(e_op.target);
    if (branch) begin
      pc_next = tgt_ext[PC_W-1:0];
    end else if (live && !e_op.halt) begin
      pc_next = pc_inc;
    end else begin
      pc_next = pc;
    end
    pc_ext = 32'(pc_next);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      e_op <= head_op;
    end
    if (c_reg_we) begin
      rf_fwd_addr <= e_rw;
      rf_fwd_data <= res;
    end
    if (c_mem_we) begin
      mem_fwd_addr <= e_mw;
      mem_fwd_data <= res;
    end
    if (e_commit) begin
      next_pc     <= pc_ext[9:0];
      print_valid <= live && e_op.print;
      print_value <= (live && e_op.print) ? src_val : '0;
      halted      <= halt_flag || e_op.halt;
    end
    if (rst) begin
      clearing      <= 1'b1;
      clr_idx       <= '0;
      e_valid       <= 1'b0;
      out_valid     <= 1'b0;
      pc            <= '0;
      halt_flag     <= 1'b0;
      rf_fwd_valid  <= 1'b0;
      mem_fwd_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_ext == 32'(CLR_DEPTH - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_idx <= clr_idx + 1'b1;
        end
      end
      if (pop) begin
        e_valid <= 1'b1;
      end else if (e_commit) begin
        e_valid <= 1'b0;
      end
      if (e_commit) begin
        out_valid <= 1'b1;
        pc        <= pc_next;
        halt_flag <= halt_flag || e_op.halt;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (c_reg_we) begin
        rf_fwd_valid <= 1'b1;
      end
      if (c_mem_we) begin
        mem_fwd_valid <= 1'b1;
      end
    end
  end

endmodule

/* sv/tiny_register_machine_execute.sv */
// Top level of the tiny register machine execute block.
// Ties front decoder, request queue and back end. Depends on trm_pkg,
// trm_front, trm_queue, trm_back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+----------------------------------------
//   input    | in_valid / in_stall    | command, first_*, second_*, jump_target
//   output   | out_valid / out_stall  | next_pc, print_valid, print_value, halted
//
// One request per cycle sustained unless an output stall or the clearing pass
// holds the flow; a request passes a queue slot, then the execute stage with
// registered RAM reads. After reset a clearing pass zeroes the data memory and
// registers over max(MEM_WORDS, NUM_REGS) words, with in_stall high throughout.
// An output stall backs up into the two-entry queue, then raises in_stall.
module tiny_register_machine_execute
  import trm_pkg::*;
#(
  parameter int NUM_REGS   = 5,
  parameter int MEM_WORDS  = 64,
  parameter int PROG_WORDS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         command,
  input  logic [1:0]         first_kind,
  input  logic [2:0]         first_reg,
  input  logic [5:0]         first_addr,
  input  logic [30:0]        first_value,
  input  logic [1:0]         second_kind,
  input  logic [2:0]         second_reg,
  input  logic [5:0]         second_addr,
  input  logic [30:0]        second_value,
  input  logic [9:0]         jump_target,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         next_pc,
  output logic               print_valid,
  output logic signed [31:0] print_value,
  output logic               halted
);

  op_t  dec_op;
  op_t  head_op;
  logic head_valid;
  logic q_full;
  logic pop;
  logic clearing;
  logic push;

  assign in_stall = q_full || clearing;
  assign push     = in_valid && !in_stall;

  trm_front #(
    .NUM_REGS   (NUM_REGS),
    .MEM_WORDS  (MEM_WORDS),
    .PROG_WORDS (PROG_WORDS)
  ) u_front (
    .command      (command),
    .first_kind   (first_kind),
    .first_reg    (first_reg),
    .first_addr   (first_addr),
    .first_value  (first_value),
    .second_kind  (second_kind),
    .second_reg   (second_reg),
    .second_addr  (second_addr),
    .second_value (second_value),
    .jump_target  (jump_target),
    .op           (dec_op)
  );

  trm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (dec_op),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op),
    .full       (q_full)
  );

  trm_back #(
    .NUM_REGS   (NUM_REGS),
    .MEM_WORDS  (MEM_WORDS),
    .PROG_WORDS (PROG_WORDS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_op     (head_op),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .next_pc     (next_pc),
    .print_valid (print_valid),
    .print_value (print_value),
    .halted      (halted)
  );

endmodule

/* dv/trm_execute_result_check.sv */
// Result checker for tiny_register_machine_execute: mirrors the machine state,
// predicts one result per accepted request and compares accepted results in order.
// Depends on trm_pkg for command and operand-kind codes.
`timescale 1ns / 100ps

module trm_execute_result_check
  import trm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  command,
  input  logic [1:0]  first_kind,
  input  logic [2:0]  first_reg,
  input  logic [5:0]  first_addr,
  input  logic [30:0] first_value,
  input  logic [1:0]  second_kind,
  input  logic [2:0]  second_reg,
  input  logic [5:0]  second_addr,
  input  logic [30:0] second_value,
  input  logic [9:0]  jump_target,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [9:0]  next_pc,
  input  logic        print_valid,
  input  logic [31:0] print_value,
  input  logic        halted,
  output int          failures,
  output int          outstanding
);

  localparam int REG_COUNT = 5;
  localparam int MEM_DEPTH = 64;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [9:0]  pc;
    logic        pvalid;
    logic [31:0] pval;
    logic        halt;
  } machine_result_t;

  logic [31:0]     reg_file [REG_COUNT];
  logic [31:0]     data_mem [MEM_DEPTH];
  logic [9:0]      pc_q;
  logic            halt_q;
  machine_result_t expected_results [$];

  initial begin
    failures = 0;
    outstanding = 0;
  end

  function automatic logic [31:0] read_reg(input logic [2:0] idx);
    return (idx < REG_COUNT) ? reg_file[idx] : 32'd0;
  endfunction

  function automatic void write_reg(input logic [2:0] idx, input logic [31:0] value);
    if (idx < REG_COUNT) reg_file[idx] = value;
  endfunction

  function automatic logic [31:0] source_word(input logic [1:0] kind, input logic [2:0] idx,
                                              input logic [5:0] addr, input logic [30:0] imm);
    if (kind == KIND_REG) return read_reg(idx);
    if (kind == KIND_MEM) return data_mem[addr];
    return {1'b0, imm};
  endfunction

  // Execute one instruction on the mirrored state and return what the block reports.
  function automatic machine_result_t execute_instruction(
      input logic [2:0] cmd, input logic [1:0] k1, input logic [2:0] r1,
      input logic [5:0] a1, input logic [30:0] v1, input logic [1:0] k2,
      input logic [2:0] r2, input logic [5:0] a2, input logic [30:0] v2,
      input logic [9:0] target);
    machine_result_t res;
    logic            branch;
    logic            advance;
    logic [31:0]     dst;
    logic [31:0]     src;
    res = '0;
    branch = 1'b0;
    advance = 1'b1;
    if (halt_q) begin
      advance = 1'b0;
    end else begin
      case (cmd)
        CMD_HLT: begin
          halt_q = 1'b1;
          advance = 1'b0;
        end
        CMD_PRN: begin
          res.pvalid = 1'b1;
          res.pval = source_word(k1, r1, a1, v1);
        end
        CMD_JMP: branch = (k1 != KIND_REG) || (read_reg(r1) == 32'd0);
        CMD_JPN: begin
          dst = read_reg(r1);
          branch = (dst == 32'd0) || dst[31];
        end
        CMD_ADD, CMD_SUB: begin
          dst = read_reg(r1);
          src = source_word(k2, r2, a2, v2);
          write_reg(r1, (cmd == CMD_ADD) ? dst + src : dst - src);
        end
        CMD_MOV: begin
          if (k1 == KIND_REG) begin
            if (k2 == KIND_REG) write_reg(r2, read_reg(r1));
            else if (k2 == KIND_MEM) data_mem[a2] = read_reg(r1);
            else write_reg(r1, {1'b0, v2});
          end else if (k1 == KIND_MEM) begin
            if (k2 == KIND_REG) write_reg(r2, data_mem[a1]);
            else if (k2 != KIND_MEM) data_mem[a1] = {1'b0, v2};
          end
        end
        default: ;
      endcase
    end
    if (branch) pc_q = target;
    else if (advance) pc_q = pc_q + 10'd1;
    res.pc = pc_q;
    res.halt = halt_q;
    return res;
  endfunction

  always @(posedge clk) begin
    machine_result_t want;
    if (rst) begin
      foreach (reg_file[i]) reg_file[i] = '0;
      foreach (data_mem[i]) data_mem[i] = '0;
      pc_q = '0;
      halt_q = 1'b0;
      expected_results.delete();
    end else begin
      // Compare before predicting so a result can never match its own request early.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (failures < REPORT_LIMIT)
            $display("%0t: result with no request pending: next_pc %0d halted %0b",
                     $realtime, next_pc, halted);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (next_pc !== want.pc || print_valid !== want.pvalid ||
              print_value !== want.pval || halted !== want.halt) begin
            if (failures < REPORT_LIMIT) begin
              $write("%0t: result mismatch (expected/actual): next_pc %0d/%0d ",
                     $realtime, want.pc, next_pc);
              $display("print_valid %0b/%0b print_value %h/%h halted %0b/%0b",
                       want.pvalid, print_valid, want.pval, print_value,
                       want.halt, halted);
            end
            failures++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(execute_instruction(
          command, first_kind, first_reg, first_addr, first_value,
          second_kind, second_reg, second_addr, second_value, jump_target));
    end
    outstanding = expected_results.size();
  end

endmodule

/* dv/tb_tiny_register_machine_execute.sv */
// Testbench top for tiny_register_machine_execute: drives directed and random
// instruction requests with random idling and gives the verdict.
// Depends on trm_pkg, the block's RTL and trm_execute_result_check.
`timescale 1ns / 100ps

module tb_tiny_register_machine_execute;
  import trm_pkg::*;

  localparam logic [1:0]  KIND_IMM    = 2'd2;
  localparam logic [1:0]  KIND_SPARE  = 2'd3;
  localparam logic [2:0]  CMD_UNUSED  = 3'd7;
  localparam logic [30:0] VALUE_MAX   = 31'h7FFF_FFFF;
  localparam int          PHASE_ITEMS = 280;
  localparam int          DIRECTED    = 26;
  localparam int          QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  first_kind;
    logic [2:0]  first_reg;
    logic [5:0]  first_addr;
    logic [30:0] first_value;
    logic [1:0]  second_kind;
    logic [2:0]  second_reg;
    logic [5:0]  second_addr;
    logic [30:0] second_value;
    logic [9:0]  jump_target;
  } instruction_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         command = '0;
  logic [1:0]         first_kind = '0;
  logic [2:0]         first_reg = '0;
  logic [5:0]         first_addr = '0;
  logic [30:0]        first_value = '0;
  logic [1:0]         second_kind = '0;
  logic [2:0]         second_reg = '0;
  logic [5:0]         second_addr = '0;
  logic [30:0]        second_value = '0;
  logic [9:0]         jump_target = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [9:0]         next_pc;
  logic               print_valid;
  logic signed [31:0] print_value;
  logic               halted;
  int                 failures;
  int                 outstanding;
  int                 send_idle_pct = 34;
  int                 recv_stall_pct = 45;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  tiny_register_machine_execute dut (.*);

  trm_execute_result_check u_result_check (
    .clk, .rst, .in_valid, .in_stall, .command, .first_kind, .first_reg, .first_addr,
    .first_value, .second_kind, .second_reg, .second_addr, .second_value, .jump_target,
    .out_valid, .out_stall, .next_pc, .print_valid, .print_value, .halted,
    .failures, .outstanding
  );

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  function automatic instruction_t pack_instr(
      input logic [2:0] cmd, input logic [1:0] k1, input logic [2:0] r1,
      input logic [5:0] a1, input logic [30:0] v1, input logic [1:0] k2,
      input logic [2:0] r2, input logic [5:0] a2, input logic [30:0] v2,
      input logic [9:0] target);
    return '{cmd, k1, r1, a1, v1, k2, r2, a2, v2, target};
  endfunction

  function automatic logic [1:0] random_kind();
    return ($urandom_range(9) == 0) ? KIND_SPARE : 2'($urandom_range(2));
  endfunction

  // Mostly valid registers, now and then an index past the register file (5 to 7).
  function automatic logic [2:0] random_reg();
    return ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
  endfunction

  // Half the accesses hit a few low words so stores get read back.
  function automatic logic [5:0] random_addr();
    return $urandom_range(1) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
  endfunction

  function automatic logic [30:0] random_value();
    case ($urandom_range(3))
      0: return 31'($urandom_range(15));
      1: return VALUE_MAX - 31'($urandom_range(15));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic instruction_t random_instr();
    instruction_t it;
    int           pick;
    pick = $urandom_range(99);
    if (pick < 3) it.command = CMD_UNUSED;
    else if (pick < 33) it.command = CMD_MOV;
    else if (pick < 53) it.command = CMD_ADD;
    else if (pick < 68) it.command = CMD_SUB;
    else if (pick < 83) it.command = CMD_PRN;
    else if (pick < 92) it.command = CMD_JMP;
    else it.command = CMD_JPN;
    it.first_kind = random_kind();
    it.first_reg = random_reg();
    it.first_addr = random_addr();
    it.first_value = random_value();
    it.second_kind = random_kind();
    it.second_reg = random_reg();
    it.second_addr = random_addr();
    it.second_value = random_value();
    it.jump_target = 10'($urandom_range(1023));
    return it;
  endfunction

  // Enter and leave at a falling edge; hold the request until it is taken.
  task automatic send_request(input instruction_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= item.command;
    first_kind <= item.first_kind;
    first_reg <= item.first_reg;
    first_addr <= item.first_addr;
    first_value <= item.first_value;
    second_kind <= item.second_kind;
    second_reg <= item.second_reg;
    second_addr <= item.second_addr;
    second_value <= item.second_value;
    jump_target <= item.jump_target;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: wraparound arithmetic, every move form, prints, branches, odd cases.
    send_request(pack_instr(CMD_MOV, KIND_REG, 0, 0, 0, KIND_IMM, 0, 0, VALUE_MAX, 0));
    send_request(pack_instr(CMD_ADD, KIND_REG, 0, 0, 0, KIND_REG, 0, 0, 0, 0));
    send_request(pack_instr(CMD_ADD, KIND_SPARE, 0, 0, 0, KIND_IMM, 0, 0, 2, 0));
    send_request(pack_instr(CMD_SUB, KIND_REG, 1, 0, 0, KIND_IMM, 0, 0, 5, 0));
    send_request(pack_instr(CMD_MOV, KIND_REG, 1, 0, 0, KIND_MEM, 0, 63, 0, 0));
    send_request(pack_instr(CMD_MOV, KIND_MEM, 0, 0, 0, KIND_SPARE, 0, 0, 123, 0));
    send_request(pack_instr(CMD_MOV, KIND_MEM, 0, 63, 0, KIND_REG, 4, 0, 0, 0));
    send_request(pack_instr(CMD_ADD, KIND_REG, 4, 0, 0, KIND_MEM, 0, 0, 0, 0));
    send_request(pack_instr(CMD_SUB, KIND_REG, 4, 0, 0, KIND_MEM, 0, 63, 0, 0));
    send_request(pack_instr(CMD_SUB, KIND_REG, 2, 0, 0, KIND_REG, 4, 0, 0, 0));
    send_request(pack_instr(CMD_MOV, KIND_REG, 2, 0, 0, KIND_REG, 3, 0, 0, 0));
    send_request(pack_instr(CMD_PRN, KIND_REG, 1, 0, 0, KIND_REG, 0, 0, 0, 0));
    send_request(pack_instr(CMD_PRN, KIND_MEM, 0, 63, 0, KIND_REG, 0, 0, 0, 0));
    send_request(pack_instr(CMD_PRN, KIND_IMM, 0, 0, VALUE_MAX, KIND_REG, 0, 0, 0, 0));
    send_request(pack_instr(CMD_PRN, KIND_SPARE, 7, 63, 0, KIND_SPARE, 7, 63, VALUE_MAX,
                            1023));
    // Branch to the last word, then let the counter wrap to zero.
    send_request(pack_instr(CMD_JMP, KIND_REG, 0, 0, 0, KIND_REG, 0, 0, 0, 1023));
    send_request(pack_instr(CMD_ADD, KIND_REG, 6, 0, 0, KIND_REG, 1, 0, 0, 0));
    send_request(pack_instr(CMD_JMP, KIND_REG, 1, 0, 0, KIND_REG, 0, 0, 0, 100));
    send_request(pack_instr(CMD_JMP, KIND_MEM, 0, 0, 0, KIND_REG, 0, 0, 0, 512));
    send_request(pack_instr(CMD_JPN, KIND_SPARE, 1, 0, 0, KIND_REG, 0, 0, 0, 0));
    send_request(pack_instr(CMD_JPN, KIND_REG, 4, 0, 0, KIND_REG, 0, 0, 0, 7));
    send_request(pack_instr(CMD_JPN, KIND_REG, 5, 0, 0, KIND_REG, 0, 0, 0, 9));
    send_request(pack_instr(CMD_MOV, KIND_REG, 7, 0, 0, KIND_IMM, 0, 0, VALUE_MAX, 0));
    send_request(pack_instr(CMD_MOV, KIND_MEM, 0, 5, 0, KIND_MEM, 0, 6, 0, 0));
    send_request(pack_instr(CMD_MOV, KIND_IMM, 0, 0, 0, KIND_REG, 2, 0, 0, 0));
    send_request(pack_instr(CMD_UNUSED, KIND_REG, 3, 1, 1, KIND_REG, 3, 1, 1, 3));

    repeat (PHASE_ITEMS - DIRECTED) send_request(random_instr());
    send_idle_pct = 45;
    recv_stall_pct = 34;
    repeat (PHASE_ITEMS) send_request(random_instr());
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (PHASE_ITEMS) send_request(random_instr());

    // Halt last: from here on the machine must stay frozen.
    send_request(pack_instr(CMD_HLT, random_kind(), random_reg(), random_addr(),
                            random_value(), random_kind(), random_reg(), random_addr(),
                            random_value(), 10'($urandom_range(1023))));
    repeat (5) send_request(random_instr());
    send_request(pack_instr(CMD_HLT, KIND_REG, 0, 0, 0, KIND_REG, 0, 0, 0, 0));
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (failures == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

/* tiny_register_machine_execute.f */
sv/trm_pkg.sv
sv/trm_ram.sv
sv/trm_front.sv
sv/trm_queue.sv
sv/trm_back.sv
sv/tiny_register_machine_execute.sv
dv/trm_execute_result_check.sv
dv/tb_tiny_register_machine_execute.sv
